[rtl/telnet_option_responder_core_defines.svh]
// Assertion macros used by the checker file of the option responder.
`ifndef TELNET_OPTION_RESPONDER_CORE_DEFINES_SVH
`define TELNET_OPTION_RESPONDER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TOR_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("option responder check failed");

// Next-cycle implication, checked outside reset.
`define TOR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("option responder check failed");

`endif

[rtl/tor_pkg.sv]
`default_nettype none

package tor_pkg;

  // Telnet protocol bytes.
  localparam logic [7:0] B_IAC  = 8'hFF;
  localparam logic [7:0] B_DO   = 8'd253;
  localparam logic [7:0] B_WONT = 8'd252;
  localparam logic [7:0] B_WILL = 8'd251;
  localparam logic [7:0] B_SB   = 8'd250;
  localparam logic [7:0] B_SE   = 8'd240;
  localparam logic [7:0] B_IS   = 8'd0;

  localparam logic [7:0] OPT_ECHO  = 8'd1;
  localparam logic [7:0] OPT_SGA   = 8'd3;
  localparam logic [7:0] OPT_TTYPE = 8'd24;
  localparam logic [7:0] OPT_NAWS  = 8'd31;

  // Terminal name sent in the terminal type reply.
  localparam int NAME_MAX_LEN = 14;
  localparam int TTYPE_LEN    = 14;
  localparam int NAME_LEN     = (TTYPE_LEN > NAME_MAX_LEN) ? NAME_MAX_LEN : TTYPE_LEN;
  localparam int NAME_IDX_W   = $clog2(NAME_MAX_LEN);
  localparam logic [7:0] TERM_NAME [NAME_MAX_LEN] = '{
    8'h78, 8'h74, 8'h65, 8'h72, 8'h6D, 8'h2D, 8'h32,
    8'h35, 8'h36, 8'h63, 8'h6F, 8'h6C, 8'h6F, 8'h72
  };

  // Reply lengths in bytes.
  localparam int SHORT_REPLY_LEN = 3;
  localparam int NAWS_REPLY_LEN  = 12;
  localparam int TTYPE_REPLY_LEN = NAME_LEN + 6;
  localparam int REPLY_MAX_LEN   = (TTYPE_REPLY_LEN > NAWS_REPLY_LEN) ?
                                   TTYPE_REPLY_LEN : NAWS_REPLY_LEN;
  localparam int IDX_W           = $clog2(REPLY_MAX_LEN);

  // Reply kinds handed from the parser to the emitter.
  localparam logic [2:0] K_NONE   = 3'd0;
  localparam logic [2:0] K_WILL   = 3'd1;
  localparam logic [2:0] K_WONT   = 3'd2;
  localparam logic [2:0] K_DOECHO = 3'd3;
  localparam logic [2:0] K_NAWS   = 3'd4;
  localparam logic [2:0] K_TTYPE  = 3'd5;

  // Reply queue.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [15:0] COLS_RESET = 16'd80;
  localparam logic [15:0] ROWS_RESET = 16'd24;

  localparam logic CFG_COLS = 1'b0;
  localparam logic CFG_ROWS = 1'b1;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] opt;
    logic       naws;
    logic       sga;
    logic       ttype;
  } cmd_t;

endpackage

`default_nettype wire

[rtl/telnet_option_responder_core.sv]
`default_nettype none

// Telnet option responder. Received bytes arrive on the in channel and are
// taken at one beat per cycle whenever the reply queue has room. The front
// parser tracks the IAC, command, option triple and subnegotiation framing;
// each byte that calls for a reply pushes one short reply descriptor into a
// four-entry queue, and data bytes leave nothing behind. The back emitter
// expands each descriptor into its reply burst, one byte per cycle through a
// registered output, with last set on the final byte of each burst: three
// bytes for WILL, WONT or DO ECHO, twelve for the window size reply and six
// plus the name length (twenty by default) for the terminal type reply. A
// reply byte passes through its queue entry and the registered output. Input
// stalls only when four replies are pending, so a sustained rate of one byte
// per cycle holds until the emitter, which sets the rate while bursts are
// pending at one output beat per cycle while out_ready is high, falls behind.
// The naws_on, sga_on and ttype_done flags on each reply byte show the agreed
// options after the input byte that caused that reply. The window size comes
// from term_cols (index 0) and term_rows (index 1), which reset to 80 and 24
// and should be written only while no reply is pending.
module telnet_option_responder_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic  [7:0] in_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic       [7:0] out_byte,
  output logic             last,
  output logic             naws_on,
  output logic             sga_on,
  output logic             ttype_done,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data
);

  // Window size registers, read by the emitter while it builds the reply.
  logic [15:0] term_cols;
  logic [15:0] term_rows;

  always_ff @(posedge clk) begin
    if (rst) begin
      term_cols <= tor_pkg::COLS_RESET;
      term_rows <= tor_pkg::ROWS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tor_pkg::CFG_COLS: term_cols <= cfg_data;
        tor_pkg::CFG_ROWS: term_rows <= cfg_data;
      endcase
    end
  end

  // Descriptor path between the parser and the emitter.
  logic          q_push;
  logic          q_pop;
  logic          q_full;
  logic          q_nonempty;
  tor_pkg::cmd_t q_in;
  tor_pkg::cmd_t q_head;

  tor_parse u_parse (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_byte  (in_byte),
    .q_full   (q_full),
    .in_ready (in_ready),
    .push     (q_push),
    .push_cmd (q_in)
  );

  tor_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_in),
    .pop      (q_pop),
    .full     (q_full),
    .nonempty (q_nonempty),
    .head     (q_head)
  );

  tor_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .q_nonempty (q_nonempty),
    .q_head     (q_head),
    .cols       (term_cols),
    .rows       (term_rows),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .last       (last),
    .naws_on    (naws_on),
    .sga_on     (sga_on),
    .ttype_done (ttype_done)
  );

endmodule

`default_nettype wire

[rtl/tor_fifo.sv]
`default_nettype none

module tor_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire tor_pkg::cmd_t push_cmd,
  input  wire logic          pop,
  output logic               full,
  output logic               nonempty,
  output tor_pkg::cmd_t      head
);

  tor_pkg::cmd_t mem [tor_pkg::QUEUE_DEPTH];
  logic [tor_pkg::QPTR_W-1:0] wr_ptr;
  logic [tor_pkg::QPTR_W-1:0] rd_ptr;
  logic [tor_pkg::QPTR_W:0]   count;

  assign full     = (count == (tor_pkg::QPTR_W+1)'(tor_pkg::QUEUE_DEPTH));
  assign nonempty = (count != '0);
  assign head     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/tor_parse.sv]
`default_nettype none

module tor_parse (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  input  wire logic     [7:0] in_byte,
  input  wire logic     q_full,
  output logic          in_ready,
  output logic          push,
  output tor_pkg::cmd_t push_cmd
);

  localparam logic [2:0] PH_DATA   = 3'd0;
  localparam logic [2:0] PH_CMD    = 3'd1;
  localparam logic [2:0] PH_OPT    = 3'd2;
  localparam logic [2:0] PH_SUB    = 3'd3;
  localparam logic [2:0] PH_SUBIAC = 3'd4;

  logic [2:0] phase, phase_next;
  logic [7:0] held_cmd, held_cmd_next;
  logic [7:0] sub_opt, sub_opt_next;
  logic       naws, naws_next;
  logic       sga, sga_next;
  logic       ttype, ttype_next;
  logic [2:0] kind;
  logic       accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    phase_next    = phase;
    held_cmd_next = held_cmd;
    sub_opt_next  = sub_opt;
    naws_next     = naws;
    sga_next      = sga;
    ttype_next    = ttype;
    kind          = tor_pkg::K_NONE;
    unique case (phase)
      PH_CMD: begin
        held_cmd_next = in_byte;
        phase_next    = PH_OPT;
      end
      PH_OPT: begin
        phase_next = PH_DATA;
        if (held_cmd == tor_pkg::B_DO) begin
          if (in_byte == tor_pkg::OPT_NAWS) begin
            kind      = tor_pkg::K_NAWS;
            naws_next = 1'b1;
          end else if (in_byte == tor_pkg::OPT_SGA) begin
            kind     = tor_pkg::K_WILL;
            sga_next = 1'b1;
          end else if (in_byte == tor_pkg::OPT_TTYPE) begin
            kind = tor_pkg::K_WILL;
          end else begin
            kind = tor_pkg::K_WONT;
          end
        end else if (held_cmd == tor_pkg::B_WILL) begin
          if (in_byte == tor_pkg::OPT_ECHO) begin
            kind = tor_pkg::K_DOECHO;
          end
        end else if (held_cmd == tor_pkg::B_SB) begin
          sub_opt_next = in_byte;
          phase_next   = PH_SUB;
        end
      end
      PH_SUB: begin
        if (in_byte == tor_pkg::B_IAC) begin
          phase_next = PH_SUBIAC;
        end
      end
      PH_SUBIAC: begin
        if (in_byte == tor_pkg::B_SE) begin
          phase_next = PH_DATA;
          if (sub_opt == tor_pkg::OPT_TTYPE) begin
            kind       = tor_pkg::K_TTYPE;
            ttype_next = 1'b1;
          end
        end else if (in_byte != tor_pkg::B_IAC) begin
          phase_next = PH_SUB;
        end
      end
      default: begin
        phase_next = (in_byte == tor_pkg::B_IAC) ? PH_CMD : PH_DATA;
      end
    endcase
  end

  assign push           = accept && (kind != tor_pkg::K_NONE);
  assign push_cmd.kind  = kind;
  assign push_cmd.opt   = in_byte;
  assign push_cmd.naws  = naws_next;
  assign push_cmd.sga   = sga_next;
  assign push_cmd.ttype = ttype_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_DATA;
      held_cmd <= '0;
      sub_opt  <= '0;
      naws     <= 1'b0;
      sga      <= 1'b0;
      ttype    <= 1'b0;
    end else if (accept) begin
      phase    <= phase_next;
      held_cmd <= held_cmd_next;
      sub_opt  <= sub_opt_next;
      naws     <= naws_next;
      sga      <= sga_next;
      ttype    <= ttype_next;
    end
  end

endmodule

`default_nettype wire

[rtl/tor_emit.sv]
`default_nettype none

module tor_emit (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_nonempty,
  input  wire tor_pkg::cmd_t q_head,
  input  wire logic   [15:0] cols,
  input  wire logic   [15:0] rows,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic         [7:0] out_byte,
  output logic               last,
  output logic               naws_on,
  output logic               sga_on,
  output logic               ttype_done
);

  logic [tor_pkg::IDX_W-1:0]      idx;
  logic [tor_pkg::IDX_W-1:0]      name_off;
  logic [tor_pkg::NAME_IDX_W-1:0] name_idx;
  logic [7:0]                     cur_byte;
  logic                           cur_last;
  logic                           load;

  assign load     = q_nonempty && (!out_valid || out_ready);
  assign pop      = load && cur_last;
  assign name_off = idx - tor_pkg::IDX_W'(4);
  assign name_idx = name_off[tor_pkg::NAME_IDX_W-1:0];

  always_comb begin
    cur_byte = tor_pkg::B_IAC;
    cur_last = 1'b0;
    unique case (q_head.kind)
      tor_pkg::K_NAWS: begin
        cur_last = (idx == tor_pkg::IDX_W'(tor_pkg::NAWS_REPLY_LEN - 1));
        unique case (idx)
          tor_pkg::IDX_W'(1):  cur_byte = tor_pkg::B_WILL;
          tor_pkg::IDX_W'(2):  cur_byte = tor_pkg::OPT_NAWS;
          tor_pkg::IDX_W'(4):  cur_byte = tor_pkg::B_SB;
          tor_pkg::IDX_W'(5):  cur_byte = tor_pkg::OPT_NAWS;
          tor_pkg::IDX_W'(6):  cur_byte = cols[15:8];
          tor_pkg::IDX_W'(7):  cur_byte = cols[7:0];
          tor_pkg::IDX_W'(8):  cur_byte = rows[15:8];
          tor_pkg::IDX_W'(9):  cur_byte = rows[7:0];
          tor_pkg::IDX_W'(11): cur_byte = tor_pkg::B_SE;
          default:             cur_byte = tor_pkg::B_IAC;
        endcase
      end
      tor_pkg::K_TTYPE: begin
        cur_last = (idx == tor_pkg::IDX_W'(tor_pkg::TTYPE_REPLY_LEN - 1));
        if (idx == tor_pkg::IDX_W'(1)) begin
          cur_byte = tor_pkg::B_SB;
        end else if (idx == tor_pkg::IDX_W'(2)) begin
          cur_byte = tor_pkg::OPT_TTYPE;
        end else if (idx == tor_pkg::IDX_W'(3)) begin
          cur_byte = tor_pkg::B_IS;
        end else if (idx >= tor_pkg::IDX_W'(4) &&
                     idx < tor_pkg::IDX_W'(4 + tor_pkg::NAME_LEN)) begin
          cur_byte = tor_pkg::TERM_NAME[name_idx];
        end else if (idx == tor_pkg::IDX_W'(tor_pkg::TTYPE_REPLY_LEN - 1)) begin
          cur_byte = tor_pkg::B_SE;
        end else begin
          cur_byte = tor_pkg::B_IAC;
        end
      end
      default: begin
        cur_last = (idx == tor_pkg::IDX_W'(tor_pkg::SHORT_REPLY_LEN - 1));
        if (idx == tor_pkg::IDX_W'(1)) begin
          if (q_head.kind == tor_pkg::K_WILL) begin
            cur_byte = tor_pkg::B_WILL;
          end else if (q_head.kind == tor_pkg::K_WONT) begin
            cur_byte = tor_pkg::B_WONT;
          end else begin
            cur_byte = tor_pkg::B_DO;
          end
        end else if (idx == tor_pkg::IDX_W'(2)) begin
          cur_byte = q_head.opt;
        end else begin
          cur_byte = tor_pkg::B_IAC;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        idx       <= cur_last ? '0 : idx + 1'b1;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte   <= cur_byte;
      last       <= cur_last;
      naws_on    <= q_head.naws;
      sga_on     <= q_head.sga;
      ttype_done <= q_head.ttype;
    end
  end

endmodule

`default_nettype wire

[rtl/tor_checker.sv]
`default_nettype none

`include "telnet_option_responder_core_defines.svh"

module tor_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       last,
  input wire logic       naws_on,
  input wire logic       sga_on,
  input wire logic       ttype_done
);

  // Option flags seen on any delivered beat so far; they never drop again.
  logic naws_seen;
  logic sga_seen;
  logic ttype_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      naws_seen  <= 1'b0;
      sga_seen   <= 1'b0;
      ttype_seen <= 1'b0;
    end else if (out_valid && out_ready) begin
      naws_seen  <= naws_seen | naws_on;
      sga_seen   <= sga_seen | sga_on;
      ttype_seen <= ttype_seen | ttype_done;
    end
  end

  `TOR_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready,
    out_valid && $stable(out_byte) && $stable(last))
  `TOR_ASSERT_NEXT(a_burst_continues, clk, rst, out_valid && out_ready && !last, out_valid)
  `TOR_ASSERT_NOW(a_flags_sticky, clk, rst, out_valid,
    (naws_on || !naws_seen) && (sga_on || !sga_seen) && (ttype_done || !ttype_seen))
  `TOR_ASSERT_NOW(a_burst_starts_iac, clk, rst, out_valid && $past(out_valid && out_ready && last),
    out_byte == tor_pkg::B_IAC)

endmodule

bind telnet_option_responder_core tor_checker u_tor_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_byte   (out_byte),
  .last       (last),
  .naws_on    (naws_on),
  .sga_on     (sga_on),
  .ttype_done (ttype_done)
);

`default_nettype wire

[tb/sv/tb_telnet_option_responder_core.sv]
`timescale 1ns / 1ps

module tb_telnet_option_responder_core;
  import tor_pkg::*;

  // The command byte DONT is not in the package, and the block treats it
  // like any other command that needs no reply.
  localparam logic [7:0] CMD_DONT = 8'd254;

  // The terminal name is kept here as text, so the prediction does not lean
  // on the name table of the package.
  localparam int TERM_NAME_LEN = 14;
  localparam logic [8*TERM_NAME_LEN-1:0] TERM_NAME_TXT = "xterm-256color";

  localparam int PHASE_ITEMS = 57;

  // Parser phases of the predictor.
  typedef enum logic [2:0] {
    PH_DATA,
    PH_CMD,
    PH_OPT,
    PH_SUB,
    PH_SUBIAC
  } parse_phase_e;

  // One reply beat as it should appear on the output channel.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       naws;
    logic       sga;
    logic       ttype;
  } reply_beat_t;

  // One row of the directed table. Where typed is set, the reply bytes are
  // written out by hand (n bytes, first byte in the top bits of reply).
  typedef struct packed {
    logic [7:0]  in_b;
    logic        typed;
    logic [1:0]  n;
    logic [23:0] reply;
  } directed_row_t;

  localparam int NUM_DIRECTED = 27;

  // The directed part walks through plain data, DO SGA, DO of an option the
  // block refuses, WILL ECHO, WILL of an option that gets no reply, DO NAWS,
  // IAC IAC as a command with the top byte value as the option, and a
  // terminal type subnegotiation with an IAC that is just content and a
  // doubled IAC right before SE.
  directed_row_t directed_tab [NUM_DIRECTED] = '{
    '{8'h00,     1'b1, 2'd0, 24'h0},
    '{B_IAC,     1'b1, 2'd0, 24'h0},
    '{B_DO,      1'b1, 2'd0, 24'h0},
    '{OPT_SGA,   1'b1, 2'd3, {B_IAC, B_WILL, OPT_SGA}},
    '{B_IAC,     1'b1, 2'd0, 24'h0},
    '{B_DO,      1'b1, 2'd0, 24'h0},
    '{OPT_ECHO,  1'b1, 2'd3, {B_IAC, B_WONT, OPT_ECHO}},
    '{B_IAC,     1'b1, 2'd0, 24'h0},
    '{B_WILL,    1'b1, 2'd0, 24'h0},
    '{OPT_ECHO,  1'b1, 2'd3, {B_IAC, B_DO, OPT_ECHO}},
    '{B_IAC,     1'b1, 2'd0, 24'h0},
    '{B_WILL,    1'b1, 2'd0, 24'h0},
    '{OPT_SGA,   1'b1, 2'd0, 24'h0},
    '{B_IAC,     1'b1, 2'd0, 24'h0},
    '{B_DO,      1'b1, 2'd0, 24'h0},
    '{OPT_NAWS,  1'b0, 2'd0, 24'h0},
    '{B_IAC,     1'b1, 2'd0, 24'h0},
    '{B_IAC,     1'b1, 2'd0, 24'h0},
    '{8'hFF,     1'b1, 2'd0, 24'h0},
    '{B_IAC,     1'b1, 2'd0, 24'h0},
    '{B_SB,      1'b1, 2'd0, 24'h0},
    '{OPT_TTYPE, 1'b1, 2'd0, 24'h0},
    '{B_IAC,     1'b1, 2'd0, 24'h0},
    '{8'h05,     1'b1, 2'd0, 24'h0},
    '{B_IAC,     1'b1, 2'd0, 24'h0},
    '{B_IAC,     1'b1, 2'd0, 24'h0},
    '{B_SE,      1'b0, 2'd0, 24'h0}
  };

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_byte;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_byte;
  logic        last;
  logic        naws_on;
  logic        sga_on;
  logic        ttype_done;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;

  // Predictor state: the parser and the agreed options, plus its own copy
  // of the window size registers.
  parse_phase_e m_phase;
  logic [7:0]   m_cmd;
  logic [7:0]   m_sub_opt;
  logic         m_naws;
  logic         m_sga;
  logic         m_ttype;
  logic [15:0]  m_cols;
  logic [15:0]  m_rows;

  // Reply bytes worked out for the byte just accepted.
  logic [7:0]  reply_burst [$];
  // Reply beats still owed by the block, oldest first.
  reply_beat_t pending_replies [$];
  // Bytes of the current random phase, waiting to be offered.
  logic [7:0]  stream_bytes [$];

  int mismatch_count = 0;
  // Knobs shared between the sender and the receiver. The long hold-off is
  // loaded by the sender and counted down by the receiver.
  bit send_no_idle = 1'b0;
  bit sink_no_idle = 1'b0;
  int long_hold_cycles = 0;

  telnet_option_responder_core dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .last       (last),
    .naws_on    (naws_on),
    .sga_on     (sga_on),
    .ttype_done (ttype_done),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // Every mismatch goes through here: one line, one count.
  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t ns: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic reset_responder_model();
    m_phase   = PH_DATA;
    m_cmd     = 8'h00;
    m_sub_opt = 8'h00;
    m_naws    = 1'b0;
    m_sga     = 1'b0;
    m_ttype   = 1'b0;
    m_cols    = 16'd80;
    m_rows    = 16'd24;
  endtask

  // Advances the predictor by one received byte and leaves the reply bytes
  // it calls for in reply_burst.
  task automatic predict_reply(input logic [7:0] b);
    int name_len;
    name_len = (TTYPE_LEN > TERM_NAME_LEN) ? TERM_NAME_LEN : TTYPE_LEN;
    reply_burst.delete();
    case (m_phase)
      PH_CMD: begin
        m_cmd   = b;
        m_phase = PH_OPT;
      end
      PH_OPT: begin
        // A completed triple. Only SB leaves the parser outside data phase.
        m_phase = PH_DATA;
        if (m_cmd == B_DO) begin
          reply_burst.push_back(B_IAC);
          if (b == OPT_TTYPE || b == OPT_NAWS || b == OPT_SGA) begin
            reply_burst.push_back(B_WILL);
            reply_burst.push_back(b);
            if (b == OPT_NAWS) begin
              // The window size follows right away, bytes sent raw.
              m_naws = 1'b1;
              reply_burst.push_back(B_IAC);
              reply_burst.push_back(B_SB);
              reply_burst.push_back(OPT_NAWS);
              reply_burst.push_back(m_cols[15:8]);
              reply_burst.push_back(m_cols[7:0]);
              reply_burst.push_back(m_rows[15:8]);
              reply_burst.push_back(m_rows[7:0]);
              reply_burst.push_back(B_IAC);
              reply_burst.push_back(B_SE);
            end
            if (b == OPT_SGA) m_sga = 1'b1;
          end else begin
            reply_burst.push_back(B_WONT);
            reply_burst.push_back(b);
          end
        end else if (m_cmd == B_WILL) begin
          if (b == OPT_ECHO) begin
            reply_burst.push_back(B_IAC);
            reply_burst.push_back(B_DO);
            reply_burst.push_back(b);
          end
        end else if (m_cmd == B_SB) begin
          m_sub_opt = b;
          m_phase   = PH_SUB;
        end
      end
      PH_SUB: begin
        if (b == B_IAC) m_phase = PH_SUBIAC;
      end
      PH_SUBIAC: begin
        // IAC SE closes; a further IAC may still start the close; anything
        // else was content.
        if (b == B_SE) begin
          m_phase = PH_DATA;
          if (m_sub_opt == OPT_TTYPE) begin
            reply_burst.push_back(B_IAC);
            reply_burst.push_back(B_SB);
            reply_burst.push_back(OPT_TTYPE);
            reply_burst.push_back(B_IS);
            for (int i = 0; i < name_len; i++) begin
              reply_burst.push_back(TERM_NAME_TXT[8*(TERM_NAME_LEN-1-i) +: 8]);
            end
            reply_burst.push_back(B_IAC);
            reply_burst.push_back(B_SE);
            m_ttype = 1'b1;
          end
        end else if (b != B_IAC) begin
          m_phase = PH_SUB;
        end
      end
      default: begin
        m_phase = (b == B_IAC) ? PH_CMD : PH_DATA;
      end
    endcase
  endtask

  // Turns reply_burst into owed beats, with last on the final byte and the
  // option flags as they stand after the byte that caused the reply.
  task automatic owe_burst();
    reply_beat_t beat;
    for (int k = 0; k < reply_burst.size(); k++) begin
      beat.data  = reply_burst[k];
      beat.last  = (k == reply_burst.size() - 1);
      beat.naws  = m_naws;
      beat.sga   = m_sga;
      beat.ttype = m_ttype;
      pending_replies.push_back(beat);
    end
  endtask

  // Offers one byte and returns at the edge that accepts it. Valid stays up
  // into the next beat when there is no gap, so it is never dropped and
  // raised in the same step.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = send_no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Configuration is only touched with the block idle: every owed beat has
  // arrived, and a further wait covers a byte still in the parser.
  task automatic wait_drained();
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_window(input logic [15:0] cols, input logic [15:0] rows);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_COLS;
    cfg_data  <= cols;
    @(posedge clk);
    cfg_index <= CFG_ROWS;
    cfg_data  <= rows;
    @(posedge clk);
    cfg_we <= 1'b0;
    m_cols = cols;
    m_rows = rows;
    @(posedge clk);
  endtask

  // Picks an option byte, mostly one the block knows about.
  function automatic logic [7:0] pick_option();
    case ($urandom_range(0, 9))
      0, 1:    return OPT_NAWS;
      2, 3:    return OPT_TTYPE;
      4:       return OPT_SGA;
      5, 6:    return OPT_ECHO;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Fills stream_bytes with one phase of random traffic. Most of it is well
  // formed negotiation with random content; the rest is plain data, open
  // subnegotiations and cut-off triples. Every byte counts toward the
  // target.
  task automatic build_stream(input int target);
    int pick;
    int n;
    logic [7:0] cmd;
    logic [7:0] rnd;
    stream_bytes.delete();
    while (stream_bytes.size() < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: cmd = B_DO;
          4, 5, 6:    cmd = B_WILL;
          7:          cmd = B_WONT;
          8:          cmd = CMD_DONT;
          default:    cmd = ($urandom_range(0, 1) != 0) ? B_IAC :
                            8'($urandom_range(0, 255));
        endcase
        stream_bytes.push_back(B_IAC);
        stream_bytes.push_back(cmd);
        stream_bytes.push_back(pick_option());
      end else if (pick < 65) begin
        stream_bytes.push_back(B_IAC);
        stream_bytes.push_back(B_SB);
        stream_bytes.push_back(($urandom_range(0, 1) != 0) ? OPT_TTYPE : pick_option());
        n = $urandom_range(0, 4);
        for (int i = 0; i < n; i++) begin
          rnd = 8'($urandom_range(0, 255));
          // An IAC in the content with a byte after it that is not SE.
          if ($urandom_range(0, 3) == 0) begin
            stream_bytes.push_back(B_IAC);
            if (rnd == B_SE) rnd = 8'h00;
          end
          stream_bytes.push_back(rnd);
        end
        // Now and then the subnegotiation is left open.
        if ($urandom_range(0, 9) != 0) begin
          if ($urandom_range(0, 4) == 0) stream_bytes.push_back(B_IAC);
          stream_bytes.push_back(B_IAC);
          stream_bytes.push_back(B_SE);
        end
      end else if (pick < 85) begin
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) begin
          stream_bytes.push_back(8'($urandom_range(0, 255)));
        end
      end else begin
        stream_bytes.push_back(B_IAC);
        if ($urandom_range(0, 1) != 0) stream_bytes.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Receiver. After each beat it holds ready low for a random stall unless
  // sink_no_idle is set, serves the long hold-off when one is loaded, and
  // checks every beat it takes against the oldest owed beat.
  initial begin : reply_sink
    int stall_left;
    logic ready_next;
    reply_beat_t want;
    stall_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (pending_replies.size() == 0) begin
          report_mismatch($sformatf("reply beat %02h with nothing owed", out_byte));
        end else begin
          want = pending_replies.pop_front();
          if (out_byte !== want.data)
            report_mismatch($sformatf("out_byte %02h, want %02h", out_byte, want.data));
          if (last !== want.last)
            report_mismatch($sformatf("last %b, want %b on byte %02h",
                                      last, want.last, want.data));
          if (naws_on !== want.naws)
            report_mismatch($sformatf("naws_on %b, want %b", naws_on, want.naws));
          if (sga_on !== want.sga)
            report_mismatch($sformatf("sga_on %b, want %b", sga_on, want.sga));
          if (ttype_done !== want.ttype)
            report_mismatch($sformatf("ttype_done %b, want %b", ttype_done, want.ttype));
        end
        stall_left = sink_no_idle ? 0 : $urandom_range(0, 4);
      end
      ready_next = 1'b1;
      if (long_hold_cycles > 0) begin
        long_hold_cycles--;
        ready_next = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        ready_next = 1'b0;
      end
      out_ready <= ready_next;
    end
  end

  // Sender and sequencing of the run.
  initial begin : stimulus
    logic [15:0] cols_set [5];
    logic [15:0] rows_set [5];
    directed_row_t row;
    reply_beat_t beat;
    int guard;
    cols_set = '{16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000};
    rows_set = '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000};
    cols_set[2] = 16'($urandom_range(0, 65535));
    rows_set[2] = 16'($urandom_range(0, 65535));

    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_byte   <= 8'h00;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_COLS;
    cfg_data  <= 16'h0000;
    reset_responder_model();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // Directed part, run on the reset window size so the NAWS reply also
    // shows the reset values. Typed rows carry their reply bytes; the
    // flags still come from the predictor.
    for (int r = 0; r < NUM_DIRECTED; r++) begin
      row = directed_tab[r];
      send_byte(row.in_b);
      predict_reply(row.in_b);
      if (row.typed) begin
        for (int k = 0; k < row.n; k++) begin
          beat.data  = row.reply[23 - 8*k -: 8];
          beat.last  = (k == row.n - 1);
          beat.naws  = m_naws;
          beat.sga   = m_sga;
          beat.ttype = m_ttype;
          pending_replies.push_back(beat);
        end
      end else begin
        owe_burst();
      end
    end
    in_valid <= 1'b0;

    // Random phases, each on its own window size. The sender waits for all
    // owed replies before each register write. Phase 1 loads a long
    // receiver hold-off while the sender keeps offering bytes back to back,
    // so the reply queue fills and the input stalls. Phase 3 runs with no
    // idling on either side.
    for (int ph = 0; ph < 5; ph++) begin
      wait_drained();
      write_window(cols_set[ph], rows_set[ph]);
      send_no_idle = (ph == 1 || ph == 3);
      sink_no_idle = (ph == 3);
      build_stream(PHASE_ITEMS);
      if (ph == 1) long_hold_cycles = 150;
      foreach (stream_bytes[i]) begin
        send_byte(stream_bytes[i]);
        predict_reply(stream_bytes[i]);
        owe_burst();
      end
      in_valid <= 1'b0;
    end

    // Let the last bursts come out, then a short quiet stretch to catch any
    // stray beat.
    guard = 0;
    while (pending_replies.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    if (pending_replies.size() != 0)
      report_mismatch($sformatf("%0d reply beats never came", pending_replies.size()));
    repeat (40) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("** telnet_option_responder_core: PASSED **");
    end else begin
      $display("** telnet_option_responder_core: FAILED **");
    end
    $finish;
  end

  // Hard limit, far beyond the slowest correct run.
  initial begin : run_limit
    #4000000;
    $display("** telnet_option_responder_core: FAILED **");
    $finish;
  end

endmodule
